// ===== src/ffba_pkg.sv =====
`default_nettype none

package ffba_pkg;

  // Unit offsets address the header store; lengths can reach the full arena.
  localparam int ADDR_W = 12;
  localparam int LEN_W  = 13;
  localparam int HDR_W  = LEN_W + 1;
  localparam int MERGE_W = 12;
  localparam int ARENA_DEPTH = 4096;

  localparam logic [LEN_W-1:0] ARENA_UNITS = 13'd4096;

  typedef enum logic [1:0] {
    CMD_ALLOC    = 2'd0,
    CMD_FREE     = 2'd1,
    CMD_COALESCE = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_EXACT  = 3'd0,
    ST_SPLIT  = 3'd1,
    ST_APPEND = 3'd2,
    ST_FULL   = 3'd3,
    ST_DONE   = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [LEN_W-1:0]  request_units;
    logic [ADDR_W-1:0] block_offset;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  result_offset;
    logic [2:0]         status;
    logic               error_flag;
    logic [MERGE_W-1:0] merge_count;
  } rsp_t;

endpackage

`default_nettype wire

// ===== src/first_fit_block_allocator.sv =====
`default_nettype none

// First-fit block allocator over a 4096-unit arena.
// The req channel carries one request: allocate request_units (header
// included), free the block at block_offset, or coalesce adjacent free blocks.
// The rsp channel returns one result per request, in order. Both channels use
// valid/stall; a transfer happens on a clock edge with valid high, stall low.
// Block headers live in a single-port-write, registered-read RAM. Every walk
// step issues a header read and checks it in the next cycle. A split adds one
// extra header write for the front of the block. During coalesce the look
// past each free block reads the header that follows it, and each merge
// writes the grown header back at pos. The header walk sets the rate.
// Only one request is in flight; req_stall is high while it is being worked.
// A finished result sits in the output register while the next request is
// accepted; if rsp_stall still holds it when the next result is ready, the
// block waits. Reset clears the arena end and the handshake state; header
// memory is not cleared, since only written headers are ever walked.
module first_fit_block_allocator (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  ffba_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output ffba_pkg::rsp_t rsp
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_CHECK,
    S_NEXT_ISSUE,
    S_NEXT_CHECK,
    S_SPLIT,
    S_DONE
  } state_t;

  localparam int AW = ffba_pkg::ADDR_W;
  localparam int LW = ffba_pkg::LEN_W;
  localparam int HW = ffba_pkg::HDR_W;
  localparam int MW = ffba_pkg::MERGE_W;

  // Registers.
  state_t         state, state_next;
  logic [1:0]     cmd, cmd_next;
  logic [LW-1:0]  req_len, req_len_next;
  logic [AW-1:0]  off, off_next;
  logic [LW-1:0]  pos, pos_next;
  logic [LW-1:0]  cur_len, cur_len_next;
  logic [LW-1:0]  arena_end, arena_end_next;
  logic [MW-1:0]  merges, merges_next;
  ffba_pkg::rsp_t res, res_next;
  logic           rsp_valid_next;
  ffba_pkg::rsp_t rsp_next;

  // Header RAM ports.
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [HW-1:0]  mem_wdata;
  logic [AW-1:0]  mem_raddr;
  logic [HW-1:0]  mem_rdata;

  // Decoded header from the read that was issued in the previous cycle.
  logic [LW-1:0]  hdr_len;
  logic           hdr_free;
  logic [LW-1:0]  nxt;
  logic [LW-1:0]  split_pos;

  assign hdr_len   = mem_rdata[LW-1:0];
  assign hdr_free  = mem_rdata[HW-1];
  assign nxt       = pos + cur_len;
  assign split_pos = pos + req_len;

  assign req_stall = (state != S_IDLE);

  ffba_ram #(
    .WIDTH(HW),
    .DEPTH(ffba_pkg::ARENA_DEPTH)
  ) u_hdr_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_comb begin
    state_next     = state;
    cmd_next       = cmd;
    req_len_next   = req_len;
    off_next       = off;
    pos_next       = pos;
    cur_len_next   = cur_len;
    arena_end_next = arena_end;
    merges_next    = merges;
    res_next       = res;
    rsp_valid_next = rsp_valid && rsp_stall;
    rsp_next       = rsp;
    mem_we         = 1'b0;
    mem_waddr      = pos[AW-1:0];
    mem_wdata      = '0;
    mem_raddr      = pos[AW-1:0];

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd_next     = req.command;
          req_len_next = req.request_units;
          off_next     = req.block_offset;
          pos_next     = '0;
          merges_next  = '0;
          res_next     = '0;
          res_next.status = ffba_pkg::ST_DONE;
          if (req.command == ffba_pkg::CMD_ALLOC && req.request_units == '0) begin
            res_next.status     = ffba_pkg::ST_FULL;
            res_next.error_flag = 1'b1;
            state_next          = S_DONE;
          end else if (req.command == ffba_pkg::CMD_ALLOC ||
                       req.command == ffba_pkg::CMD_FREE ||
                       req.command == ffba_pkg::CMD_COALESCE) begin
            state_next = S_ISSUE;
          end else begin
            // An unknown command changes nothing and reports an error.
            res_next.error_flag = 1'b1;
            state_next          = S_DONE;
          end
        end
      end

      S_ISSUE: begin
        if (pos < arena_end) begin
          mem_raddr  = pos[AW-1:0];
          state_next = S_CHECK;
        end else begin
          // The walk reached the arena end.
          state_next = S_DONE;
          case (cmd)
            ffba_pkg::CMD_ALLOC: begin
              if (req_len <= ffba_pkg::ARENA_UNITS - arena_end) begin
                mem_we                 = 1'b1;
                mem_waddr              = arena_end[AW-1:0];
                mem_wdata              = {1'b0, req_len};
                arena_end_next         = arena_end + req_len;
                res_next.result_offset = arena_end[AW-1:0];
                res_next.status        = ffba_pkg::ST_APPEND;
              end else begin
                res_next.status     = ffba_pkg::ST_FULL;
                res_next.error_flag = 1'b1;
              end
            end
            ffba_pkg::CMD_FREE: begin
              res_next.error_flag = 1'b1;
            end
            default: begin
              res_next.merge_count = merges;
            end
          endcase
        end
      end

      S_CHECK: begin
        if (hdr_len == '0 || hdr_len > arena_end - pos) begin
          // A broken header ends the walk as the arena end would.
          pos_next   = arena_end;
          state_next = S_ISSUE;
        end else begin
          case (cmd)
            ffba_pkg::CMD_ALLOC: begin
              if (hdr_free && hdr_len >= req_len) begin
                res_next.result_offset = pos[AW-1:0];
                mem_we = 1'b1;
                if (hdr_len == req_len) begin
                  mem_waddr       = pos[AW-1:0];
                  mem_wdata       = {1'b0, req_len};
                  res_next.status = ffba_pkg::ST_EXACT;
                  state_next      = S_DONE;
                end else begin
                  // The tail becomes a free block; the front is written next.
                  mem_waddr       = split_pos[AW-1:0];
                  mem_wdata       = {1'b1, hdr_len - req_len};
                  res_next.status = ffba_pkg::ST_SPLIT;
                  state_next      = S_SPLIT;
                end
              end else begin
                pos_next   = pos + hdr_len;
                state_next = S_ISSUE;
              end
            end
            ffba_pkg::CMD_FREE: begin
              if (pos < {1'b0, off}) begin
                pos_next   = pos + hdr_len;
                state_next = S_ISSUE;
              end else if (pos == {1'b0, off}) begin
                mem_we                 = 1'b1;
                mem_waddr              = pos[AW-1:0];
                mem_wdata              = {1'b1, hdr_len};
                res_next.result_offset = pos[AW-1:0];
                state_next             = S_DONE;
              end else begin
                // The offset falls inside a block.
                res_next.error_flag = 1'b1;
                state_next          = S_DONE;
              end
            end
            default: begin
              if (hdr_free) begin
                cur_len_next = hdr_len;
                state_next   = S_NEXT_ISSUE;
              end else begin
                pos_next   = pos + hdr_len;
                state_next = S_ISSUE;
              end
            end
          endcase
        end
      end

      S_NEXT_ISSUE: begin
        if (nxt < arena_end) begin
          mem_raddr  = nxt[AW-1:0];
          state_next = S_NEXT_CHECK;
        end else begin
          pos_next   = nxt;
          state_next = S_ISSUE;
        end
      end

      S_NEXT_CHECK: begin
        if (hdr_free && hdr_len != '0 && hdr_len <= arena_end - nxt) begin
          // Merge the following free block into the one at pos and look again.
          mem_we       = 1'b1;
          mem_waddr    = pos[AW-1:0];
          mem_wdata    = {1'b1, cur_len + hdr_len};
          cur_len_next = cur_len + hdr_len;
          merges_next  = merges + 1'b1;
          state_next   = S_NEXT_ISSUE;
        end else begin
          pos_next   = nxt;
          state_next = S_ISSUE;
        end
      end

      S_SPLIT: begin
        mem_we     = 1'b1;
        mem_waddr  = pos[AW-1:0];
        mem_wdata  = {1'b0, req_len};
        state_next = S_DONE;
      end

      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_valid_next = 1'b1;
          rsp_next       = res;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      arena_end <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      arena_end <= arena_end_next;
      rsp_valid <= rsp_valid_next;
    end
    cmd     <= cmd_next;
    req_len <= req_len_next;
    off     <= off_next;
    pos     <= pos_next;
    cur_len <= cur_len_next;
    merges  <= merges_next;
    res     <= res_next;
    rsp     <= rsp_next;
  end

`ifndef SYNTHESIS
  // The arena end never moves past the last unit.
  a_arena_bound: assert property (@(posedge clk) disable iff (rst)
    arena_end <= ffba_pkg::ARENA_UNITS)
    else $error("arena end past arena size");

  // An accepted request always starts work.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> state != S_IDLE)
    else $error("accepted request did not start");

  // Errors are only reported as a failed allocation or a bad free/command.
  a_error_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.error_flag |->
      rsp.status == ffba_pkg::ST_FULL || rsp.status == ffba_pkg::ST_DONE)
    else $error("error with a success status");

  // Merges are only reported by a successful coalesce.
  a_merge_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.merge_count != '0 |->
      rsp.status == ffba_pkg::ST_DONE && !rsp.error_flag && rsp.result_offset == '0)
    else $error("merge count on a non-coalesce result");
`endif

endmodule

`default_nettype wire

// ===== src/ffba_ram.sv =====
`default_nettype none

module ffba_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
